@@ rtl/mi3_pkg.sv @@
`timescale 1ns / 1ps
// Package for the 3x3 matrix inverse: item types, fixed widths and flag group.
// No dependencies; used by mi3_div_lane and matrix_inverse_3x3.
package mi3_pkg;

	localparam int DATA_W        = 32;  // element and result width
	localparam int FRAC_BITS_DEF = 16;  // default fraction bits
	localparam int PROD_W        = 64;  // element product
	localparam int COF_W         = 65;  // cofactor, signed
	localparam int ABS_W         = 64;  // cofactor magnitude
	localparam int DET_W         = 98;  // determinant, signed
	localparam int MAG_W         = 97;  // determinant magnitude
	localparam int QUO_W         = 32;  // quotient bits developed by the divider

	typedef struct packed {
		logic signed [DATA_W-1:0] m00;
		logic signed [DATA_W-1:0] m01;
		logic signed [DATA_W-1:0] m02;
		logic signed [DATA_W-1:0] m10;
		logic signed [DATA_W-1:0] m11;
		logic signed [DATA_W-1:0] m12;
		logic signed [DATA_W-1:0] m20;
		logic signed [DATA_W-1:0] m21;
		logic signed [DATA_W-1:0] m22;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] inv00;
		logic signed [DATA_W-1:0] inv01;
		logic signed [DATA_W-1:0] inv02;
		logic signed [DATA_W-1:0] inv10;
		logic signed [DATA_W-1:0] inv11;
		logic signed [DATA_W-1:0] inv12;
		logic signed [DATA_W-1:0] inv20;
		logic signed [DATA_W-1:0] inv21;
		logic signed [DATA_W-1:0] inv22;
		logic                     singular;
	} out_t;

	// Per-element status that rides along the divider
	typedef struct packed {
		logic neg;   // result sign
		logic ovf;   // quotient known to exceed 32 bits
		logic zero;  // determinant is zero
	} flags_t;

endpackage

@@ rtl/mi3_div_lane.sv @@
`timescale 1ns / 1ps
// One inverse element: 32-stage restoring divide, rounding and saturation.
// Depends on mi3_pkg.
module mi3_div_lane import mi3_pkg::*; (
	input  logic               clk,
	input  logic               adv,
	input  logic [MAG_W-1:0]   rem,
	input  logic [QUO_W-1:0]   low,
	input  logic [MAG_W-1:0]   den,
	input  flags_t             flags,
	output logic [DATA_W-1:0]  res,
	output logic               singular
);

	logic [MAG_W-1:0] rem_s [1:QUO_W];
	logic [QUO_W-1:0] low_s [1:QUO_W];
	logic [QUO_W-1:0] quo_s [1:QUO_W];
	logic [MAG_W-1:0] den_s [1:QUO_W];
	flags_t           flg_s [1:QUO_W];

	logic [QUO_W:0]   qr_sr;
	flags_t           flg_sr;
	logic [QUO_W:0]   limit;
	logic [QUO_W:0]   mag;
	logic             round_up;

	// Develop one quotient bit per stage
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [MAG_W-1:0] r_prev;
		logic [QUO_W-1:0] l_prev;
		logic [QUO_W-1:0] q_prev;
		logic [MAG_W-1:0] d_prev;
		flags_t           f_prev;
		logic [MAG_W:0]   trial;
		logic [MAG_W:0]   diff;
		if (k == 0) begin : g_first
			assign r_prev = rem;
			assign l_prev = low;
			assign q_prev = '0;
			assign d_prev = den;
			assign f_prev = flags;
		end else begin : g_next
			assign r_prev = rem_s[k];
			assign l_prev = low_s[k];
			assign q_prev = quo_s[k];
			assign d_prev = den_s[k];
			assign f_prev = flg_s[k];
		end
		assign trial = {r_prev, l_prev[QUO_W-1]};
		assign diff  = trial - {1'b0, d_prev};
		always_ff @(posedge clk) begin
			if (adv) begin
				if (trial >= {1'b0, d_prev}) begin
					rem_s[k+1] <= diff[MAG_W-1:0];
					quo_s[k+1] <= {q_prev[QUO_W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= trial[MAG_W-1:0];
					quo_s[k+1] <= {q_prev[QUO_W-2:0], 1'b0};
				end
				low_s[k+1] <= {l_prev[QUO_W-2:0], 1'b0};
				den_s[k+1] <= d_prev;
				flg_s[k+1] <= f_prev;
			end
		end
	end

	// Round to nearest, ties away from zero
	assign round_up = {rem_s[QUO_W], 1'b0} >= {1'b0, den_s[QUO_W]};

	always_ff @(posedge clk) begin
		if (adv) begin
			qr_sr  <= {1'b0, quo_s[QUO_W]} + (QUO_W+1)'(round_up);
			flg_sr <= flg_s[QUO_W];
		end
	end

	// Saturate, apply sign, force zero on a singular matrix
	assign limit = flg_sr.neg ? (QUO_W+1)'(33'h0_8000_0000) : (QUO_W+1)'(33'h0_7FFF_FFFF);
	assign mag   = (flg_sr.ovf || qr_sr > limit) ? limit : qr_sr;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (flg_sr.zero) begin
				res <= '0;
			end else if (flg_sr.neg) begin
				res <= DATA_W'((~mag) + 1'b1);
			end else begin
				res <= mag[DATA_W-1:0];
			end
			singular <= flg_sr.zero;
		end
	end

endmodule

@@ rtl/matrix_inverse_3x3.sv @@
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate and determinant, Q-format fixed point.
// Depends on mi3_pkg and mi3_div_lane.
//
//   channel | signals                          | item
//   --------+----------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_data      | nine matrix elements (in_t)
//   out     | out_valid, out_ready, out_data   | nine inverse elements, flag
//
// One item per cycle while out does not stall.
// Seven stages form products, cofactors, determinant, magnitudes and the
// overflow check; 32 divider stages develop the quotient; two stages round
// and saturate. arst_n clears only the valid bits. A stall on out freezes
// the whole pipe, so nothing is lost or repeated.
module matrix_inverse_3x3 import mi3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int NUM_W  = ABS_W + 2*FRAC_BITS;  // scaled cofactor magnitude
	localparam int CMP_W  = MAG_W + QUO_W;
	localparam int DEPTH  = 7 + QUO_W + 2;

	logic             adv;
	logic [DEPTH-1:0] vld_q;

	logic signed [PROD_W-1:0] prod_s1 [18];
	logic signed [DATA_W-1:0] e0_s1 [3];
	logic signed [COF_W-1:0]  cof_s2 [9];
	logic signed [DATA_W-1:0] e0_s2 [3];
	logic signed [COF_W-1:0]  plo_s3 [3];
	logic signed [COF_W-1:0]  phi_s3 [3];
	logic signed [COF_W-1:0]  cof_s3 [9];
	logic signed [DET_W-1:0]  term_s4 [3];
	logic signed [COF_W-1:0]  cof_s4 [9];
	logic signed [DET_W-1:0]  det_s5;
	logic signed [COF_W-1:0]  cof_s5 [9];
	logic [NUM_W-1:0]         num_s6 [9];
	logic [MAG_W-1:0]         den_s6;
	logic [8:0]               neg_s6;
	logic                     zero_s6;
	logic [MAG_W-1:0]         rem_s7 [9];
	logic [QUO_W-1:0]         low_s7 [9];
	logic [MAG_W-1:0]         den_s7;
	flags_t                   flg_s7 [9];
	logic [DATA_W-1:0]        res [9];
	logic [8:0]               sing;

	// Advance the whole pipe unless a finished item is held at the output
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// Stage 1: cofactor products
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1[0]  <= in_data.m11 * in_data.m22;
			prod_s1[1]  <= in_data.m21 * in_data.m12;
			prod_s1[2]  <= in_data.m02 * in_data.m21;
			prod_s1[3]  <= in_data.m22 * in_data.m01;
			prod_s1[4]  <= in_data.m01 * in_data.m12;
			prod_s1[5]  <= in_data.m11 * in_data.m02;
			prod_s1[6]  <= in_data.m12 * in_data.m20;
			prod_s1[7]  <= in_data.m22 * in_data.m10;
			prod_s1[8]  <= in_data.m00 * in_data.m22;
			prod_s1[9]  <= in_data.m20 * in_data.m02;
			prod_s1[10] <= in_data.m02 * in_data.m10;
			prod_s1[11] <= in_data.m12 * in_data.m00;
			prod_s1[12] <= in_data.m10 * in_data.m21;
			prod_s1[13] <= in_data.m20 * in_data.m11;
			prod_s1[14] <= in_data.m01 * in_data.m20;
			prod_s1[15] <= in_data.m21 * in_data.m00;
			prod_s1[16] <= in_data.m00 * in_data.m11;
			prod_s1[17] <= in_data.m10 * in_data.m01;
			e0_s1[0]    <= in_data.m00;
			e0_s1[1]    <= in_data.m01;
			e0_s1[2]    <= in_data.m02;
		end
	end

	// Stage 2: cofactors, row-major adjugate order
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				cof_s2[k] <= COF_W'(prod_s1[2*k]) - COF_W'(prod_s1[2*k+1]);
			end
			e0_s2 <= e0_s1;
		end
	end

	// Stage 3: determinant partial products, cofactor split in low and high halves
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= e0_s2[j] * $signed({1'b0, cof_s2[3*j][DATA_W-1:0]});
				phi_s3[j] <= e0_s2[j] * $signed(cof_s2[3*j][COF_W-1:DATA_W]);
			end
			cof_s3 <= cof_s2;
		end
	end

	// Stage 4: recombine halves
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				term_s4[j] <= (DET_W'(phi_s3[j]) <<< DATA_W) + DET_W'(plo_s3[j]);
			end
			cof_s4 <= cof_s3;
		end
	end

	// Stage 5: determinant
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
		end
	end

	// Stage 6: magnitudes and signs
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				num_s6[k] <= NUM_W'(ABS_W'(cof_s5[k][COF_W-1] ? -cof_s5[k] : cof_s5[k]))
					<< (2*FRAC_BITS);
				neg_s6[k] <= cof_s5[k][COF_W-1] ^ det_s5[DET_W-1];
			end
			den_s6  <= MAG_W'(det_s5[DET_W-1] ? -det_s5 : det_s5);
			zero_s6 <= (det_s5 == '0);
		end
	end

	// Stage 7: overflow check and divider start values
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				flg_s7[k].ovf  <= CMP_W'(num_s6[k]) >= {den_s6, {QUO_W{1'b0}}};
				flg_s7[k].neg  <= neg_s6[k];
				flg_s7[k].zero <= zero_s6;
				rem_s7[k]      <= MAG_W'(num_s6[k] >> QUO_W);
				low_s7[k]      <= num_s6[k][QUO_W-1:0];
			end
			den_s7 <= den_s6;
		end
	end

	// Nine divider lanes sharing one denominator
	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div_lane u_lane (
			.clk      (clk),
			.adv      (adv),
			.rem      (rem_s7[k]),
			.low      (low_s7[k]),
			.den      (den_s7),
			.flags    (flg_s7[k]),
			.res      (res[k]),
			.singular (sing[k])
		);
	end

	// Pack the result item
	assign out_data.inv00    = res[0];
	assign out_data.inv01    = res[1];
	assign out_data.inv02    = res[2];
	assign out_data.inv10    = res[3];
	assign out_data.inv11    = res[4];
	assign out_data.inv12    = res[5];
	assign out_data.inv20    = res[6];
	assign out_data.inv21    = res[7];
	assign out_data.inv22    = res[8];
	assign out_data.singular = &sing;

endmodule

@@ sim/tb_matrix_inverse_3x3.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for matrix_inverse_3x3: exact adjugate/determinant predictor.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
module tb_matrix_inverse_3x3 import mi3_pkg::*;;

	localparam int FRAC     = FRAC_BITS_DEF;
	localparam int WIDE_W   = 192;
	localparam int WDOG_MAX = 4000;
	localparam int TAIL     = 60;

	typedef logic signed [WIDE_W-1:0] wide_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	in_t  matrix_q[$];
	out_t inverse_q[$];
	int   errors;
	int   idle_cycles;
	int   burst_left;
	int   gap_left;
	int   stall_mode;
	int   stall_left;

	matrix_inverse_3x3 u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// cofactor a*b - c*d at full width
	function automatic wide_t cof2(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d);
		wide_t wa, wb, wc, wd;
		wa = a; wb = b; wc = c; wd = d;
		return wa * wb - wc * wd;
	endfunction

	// round(cof * 2^(2F) / det) to nearest, ties away from zero, then saturate
	function automatic logic signed [31:0] scale_cof(wide_t cof, wide_t det);
		logic [WIDE_W-1:0] num, den, quo, rem;
		logic neg;
		logic [WIDE_W-1:0] lim;
		neg = cof[WIDE_W-1] != det[WIDE_W-1];
		num = cof[WIDE_W-1] ? -(cof <<< (2 * FRAC)) : (cof <<< (2 * FRAC));
		den = det[WIDE_W-1] ? -det : det;
		quo = num / den;
		rem = num % den;
		if ((rem << 1) >= den)
			quo = quo + 1;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (quo > lim)
			quo = lim;
		return neg ? -quo[31:0] : quo[31:0];
	endfunction

	function automatic out_t predict_inverse(in_t m);
		wide_t adj[9];
		wide_t det, e0, e1, e2;
		out_t r;
		adj[0] = cof2(m.m11, m.m22, m.m21, m.m12);
		adj[1] = cof2(m.m02, m.m21, m.m22, m.m01);
		adj[2] = cof2(m.m01, m.m12, m.m11, m.m02);
		adj[3] = cof2(m.m12, m.m20, m.m22, m.m10);
		adj[4] = cof2(m.m00, m.m22, m.m20, m.m02);
		adj[5] = cof2(m.m02, m.m10, m.m12, m.m00);
		adj[6] = cof2(m.m10, m.m21, m.m20, m.m11);
		adj[7] = cof2(m.m01, m.m20, m.m21, m.m00);
		adj[8] = cof2(m.m00, m.m11, m.m10, m.m01);
		e0 = m.m00; e1 = m.m01; e2 = m.m02;
		det = e0 * adj[0] + e1 * adj[3] + e2 * adj[6];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		r.inv00 = scale_cof(adj[0], det);
		r.inv01 = scale_cof(adj[1], det);
		r.inv02 = scale_cof(adj[2], det);
		r.inv10 = scale_cof(adj[3], det);
		r.inv11 = scale_cof(adj[4], det);
		r.inv12 = scale_cof(adj[5], det);
		r.inv20 = scale_cof(adj[6], det);
		r.inv21 = scale_cof(adj[7], det);
		r.inv22 = scale_cof(adj[8], det);
		return r;
	endfunction

	function automatic in_t make_matrix(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d, logic signed [31:0] e,
			logic signed [31:0] f, logic signed [31:0] g, logic signed [31:0] h,
			logic signed [31:0] i);
		in_t m;
		m.m00 = a; m.m01 = b; m.m02 = c;
		m.m10 = d; m.m11 = e; m.m12 = f;
		m.m20 = g; m.m21 = h; m.m22 = i;
		return m;
	endfunction

	// element drawn from a class: full range, moderate Q16 value, tiny, or an extreme/one/zero
	function automatic logic signed [31:0] rand_elem(int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			2: return $signed($urandom_range(0, 64)) - 32;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh0001_0000;
					default: return 0;
				endcase
			end
		endcase
	endfunction

	function automatic in_t rand_matrix();
		in_t m;
		int kind;
		kind = $urandom_range(0, 9);
		m.m00 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		m.m01 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		m.m02 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		m.m10 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		m.m11 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		m.m12 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		m.m20 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		m.m21 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		m.m22 = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
		// copy a row now and then to force a singular matrix
		if ($urandom_range(0, 15) == 0) begin
			m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
		end
		return m;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// drive the sender at the falling edge: bursts with random gaps
	always @(negedge clk) begin
		if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (matrix_q.size() > 0 && arst_n) begin
				in_data  <= matrix_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// drive the receiver's stall pattern: free-running, periodic, or random
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 150);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= (stall_left % 5) != 0;
			default: out_ready <= $urandom_range(0, 2) != 0;
		endcase
	end

	// record accepted items, check results, watch for a hang
	always @(posedge clk) begin
		out_t want;
		if (in_valid && in_ready)
			inverse_q.push_back(predict_inverse(in_data));
		if (out_valid && out_ready) begin
			if (inverse_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				want = inverse_q.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (out_data[288 - 32 * k -: 32] !== want[288 - 32 * k -: 32]) begin
						$display("%0t: inv%0d%0d expected %h actual %h", $time, k / 3,
							k % 3, want[288 - 32 * k -: 32], out_data[288 - 32 * k -: 32]);
						errors++;
					end
				end
				if (out_data.singular !== want.singular) begin
					$display("%0t: singular expected %b actual %b", $time,
						want.singular, out_data.singular);
					errors++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles > WDOG_MAX) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		in_t m;
		errors      = 0;
		idle_cycles = 0;
		burst_left  = 0;
		gap_left    = 0;
		stall_mode  = 0;
		stall_left  = 0;
		in_valid    = 1'b0;
		out_ready   = 1'b0;
		in_data     = '0;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identity, zero, extremes, tiny determinant, singular shapes
		matrix_q.push_back(make_matrix(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
		matrix_q.push_back(make_matrix(-32'sh10000, 0, 0, 0, -32'sh10000, 0, 0, 0,
			-32'sh10000));
		matrix_q.push_back('0);
		matrix_q.push_back({9{32'h7FFF_FFFF}});
		matrix_q.push_back({9{32'h8000_0000}});
		matrix_q.push_back(make_matrix(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0,
			32'h7FFF_FFFF));
		matrix_q.push_back(make_matrix(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0,
			32'h8000_0000));
		matrix_q.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
		matrix_q.push_back(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
		matrix_q.push_back(make_matrix(32'h20000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h20000));
		matrix_q.push_back(make_matrix(0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'h10000));
		matrix_q.push_back(make_matrix(32'h10000, 32'h20000, 32'h30000, 32'h40000,
			32'h50000, 32'h60000, 32'h70000, 32'h80000, 32'h90000));
		matrix_q.push_back(make_matrix(32'h10000, 32'h20000, 32'h30000, 0, 32'h10000,
			32'h40000, 32'h50000, 32'h60000, 0));
		matrix_q.push_back(make_matrix(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 0, 0, 1));
		matrix_q.push_back(make_matrix(3, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
		matrix_q.push_back(make_matrix(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'hFFFF_FFFF));
		for (int n = 0; n < 600; n++)
			matrix_q.push_back(rand_matrix());

		// hold off until the pipe drains, then resume
		wait (matrix_q.size() == 0 && !in_valid && inverse_q.size() == 0);
		for (int n = 0; n < 700; n++) begin
			m = rand_matrix();
			matrix_q.push_back(m);
		end

		wait (matrix_q.size() == 0 && !in_valid && inverse_q.size() == 0);
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
